// ===== design/drlt_pkg.sv =====
// Shared types, constants and calendar helpers for the daylight-saving rule check.
package drlt_pkg;

  localparam int DAY_W       = 16;
  localparam int YOFF_W      = 8;
  localparam int REM_W       = 17;
  localparam int PROD_W      = 33;
  localparam int SHIFT_W     = 19;
  localparam int SEC_W       = 36;
  localparam int CFG_W       = 11;
  localparam int IDX_W       = 3;
  localparam int DIVX_W      = 25;
  localparam int RECIP_W     = 26;
  localparam int MULQ_W      = 51;
  localparam int RECIP_SHIFT = 35;

  localparam logic [REM_W-1:0]   SECS_PER_DAY  = 17'd86400;
  localparam logic [SHIFT_W-1:0] SECS_PER_HOUR = 19'd3600;
  localparam logic [2:0]         EPOCH_WEEKDAY = 3'd4;
  localparam logic [YOFF_W-1:0]  YOFF_2100     = 8'd130;
  localparam logic [YOFF_W-1:0]  YOFF_LAST     = 8'd136;
  localparam logic [DAY_W-1:0]   DAYS_LEAP     = 16'd366;
  localparam logic [DAY_W-1:0]   DAYS_COMMON   = 16'd365;
  localparam logic [DAY_W-1:0]   DAY_MAX       = 16'd49710;

  // Seconds are first divided by 128; the remaining division by 675 uses this
  // reciprocal scaled by two to the power RECIP_SHIFT.
  localparam logic [RECIP_W-1:0] DAY_RECIP     = 26'd50903317;

  localparam logic signed [11:0] OFF_MAX = 12'sd1023;
  localparam logic signed [11:0] OFF_MIN = -12'sd1024;

  localparam logic [IDX_W-1:0] REG_STD_OFFSET = 3'd0;
  localparam logic [IDX_W-1:0] REG_DST_EXTRA  = 3'd1;
  localparam logic [IDX_W-1:0] REG_DST_MODE   = 3'd2;
  localparam logic [IDX_W-1:0] REG_START_RULE = 3'd3;
  localparam logic [IDX_W-1:0] REG_END_RULE   = 3'd4;
  localparam logic [IDX_W-1:0] REG_SWITCH_HR  = 3'd5;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_ON   = 2'd1;
  localparam logic [1:0] MODE_RULE = 2'd2;

  typedef struct packed {
    logic signed [10:0] base_off;
    logic [6:0]         dst_extra_min;
    logic [1:0]         dst_mode;
    logic [9:0]         start_rule;
    logic [9:0]         end_rule;
    logic [4:0]         sw_hr;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_YEAR,
    S_RULE,
    S_MONTH,
    S_DATE,
    S_MUL,
    S_SUM,
    S_CMP,
    S_DONE
  } seq_state_t;

  function automatic logic is_leap(input logic [YOFF_W-1:0] yoff);
    return (yoff[1:0] == 2'd2) && (yoff != YOFF_2100);
  endfunction

  function automatic logic [4:0] mon_len(input logic [YOFF_W-1:0] yoff,
                                         input logic [3:0] mon);
    logic [4:0] d;
    unique case (mon)
      4'd2: d = is_leap(yoff) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      default: d = 5'd0;
    endcase
    return d;
  endfunction

  function automatic logic [2:0] add_mod7(input logic [2:0] a, input logic [2:0] b);
    logic [3:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    return s[2:0];
  endfunction

endpackage

// ===== design/drlt_div.sv =====
// Reciprocal multiplier that turns seconds since the epoch into whole days.
module drlt_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start_i,
  input  logic [31:0]                 dividend_i,
  output logic                        done_o,
  output logic [drlt_pkg::DAY_W-1:0]  quot_o
);

  logic                              run_r;
  logic                              done_r;
  logic [drlt_pkg::DIVX_W-1:0]       x_r;
  logic [drlt_pkg::DAY_W-1:0]        q_r;
  logic [drlt_pkg::MULQ_W-1:0]       prod;

  assign prod = drlt_pkg::MULQ_W'(x_r) * drlt_pkg::MULQ_W'(drlt_pkg::DAY_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= start_i;
      done_r <= run_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      x_r <= dividend_i[31:32-drlt_pkg::DIVX_W];
    end
    if (run_r) begin
      q_r <= prod[drlt_pkg::MULQ_W-1:drlt_pkg::RECIP_SHIFT];
    end
  end

  assign done_o = done_r;
  assign quot_o = q_r;

`ifndef SYNTH
  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (q_r <= drlt_pkg::DAY_MAX)) else $error("day count out of range");
`endif

endmodule

// ===== design/drlt_seq.sv =====
// Sequencer that walks years and months and evaluates both switch instants.
module drlt_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  drlt_pkg::cfg_t     cfg_i,
  input  logic               start_i,
  input  logic [31:0]        utc_i,
  input  logic               ack_i,
  output logic               idle_o,
  output logic               done_o,
  output logic               active_o,
  output logic [31:0]        utc_o
);

  drlt_pkg::seq_state_t state_r, state_nxt;

  logic [31:0]                          utc_r, utc_nxt;
  logic [drlt_pkg::DAY_W-1:0]           rdays_r, rdays_nxt;
  logic [drlt_pkg::DAY_W-1:0]           ystart_r, ystart_nxt;
  logic [drlt_pkg::YOFF_W-1:0]          yoff_r, yoff_nxt;
  logic [2:0]                           ywd_r, ywd_nxt;
  logic                                 sel_r, sel_nxt;
  logic [3:0]                           mon_r, mon_nxt;
  logic [drlt_pkg::DAY_W-1:0]           first_r, first_nxt;
  logic [2:0]                           fdw_r, fdw_nxt;
  logic [drlt_pkg::DAY_W-1:0]           day_r, day_nxt;
  logic [drlt_pkg::PROD_W-1:0]          prod_r, prod_nxt;
  logic signed [drlt_pkg::SHIFT_W-1:0]  shift_r, shift_nxt;
  logic signed [drlt_pkg::SEC_W-1:0]    s_r, s_nxt;
  logic signed [drlt_pkg::SEC_W-1:0]    e_r, e_nxt;
  logic                                 active_r, active_nxt;

  logic                                 div_start;
  logic                                 div_done;
  logic [drlt_pkg::DAY_W-1:0]           div_quot;

  logic                                 leap;
  logic [drlt_pkg::DAY_W-1:0]           ylen;
  logic [9:0]                           rule;
  logic [3:0]                           rule_mon;
  logic [2:0]                           rule_week;
  logic [2:0]                           rule_wd;
  logic                                 rule_ok;
  logic [4:0]                           mlen;
  logic [2:0]                           dd;
  logic [5:0]                           date0;
  logic [5:0]                           date;
  logic                                 date_ok;
  logic signed [drlt_pkg::SHIFT_W-1:0]  hr_sec;
  logic signed [drlt_pkg::SHIFT_W-1:0]  off_sec;
  logic signed [drlt_pkg::SEC_W-1:0]    bound;
  logic signed [drlt_pkg::SEC_W-1:0]    t_sec;

  drlt_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (utc_i),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign div_start = (state_r == drlt_pkg::S_IDLE) && start_i &&
                     (cfg_i.dst_mode == drlt_pkg::MODE_RULE);

  assign leap      = drlt_pkg::is_leap(yoff_r);
  assign ylen      = leap ? drlt_pkg::DAYS_LEAP : drlt_pkg::DAYS_COMMON;
  assign rule      = sel_r ? cfg_i.end_rule : cfg_i.start_rule;
  assign rule_mon  = rule[3:0];
  assign rule_week = rule[6:4];
  assign rule_wd   = rule[9:7];
  assign rule_ok   = (rule_mon >= 4'd1) && (rule_mon <= 4'd12) && (rule_week >= 3'd1) &&
                     (rule_week <= 3'd5) && (rule_wd <= 3'd6);
  assign mlen      = drlt_pkg::mon_len(yoff_r, mon_r);

  always_comb begin
    dd    = (rule_wd >= fdw_r) ? (rule_wd - fdw_r) : (rule_wd + 3'd7 - fdw_r);
    date0 = 6'(dd) + 6'd1;
    if (rule_week == 3'd5) begin
      date = ((date0 + 6'd28) <= 6'(mlen)) ? (date0 + 6'd28) : (date0 + 6'd21);
    end else begin
      date = date0 + 6'(rule_week - 3'd1) * 6'd7;
    end
    date_ok = (date <= 6'(mlen));
  end

  assign hr_sec  = $signed(drlt_pkg::SHIFT_W'(cfg_i.sw_hr) * drlt_pkg::SECS_PER_HOUR);
  assign off_sec = drlt_pkg::SHIFT_W'(cfg_i.base_off) * $signed(19'd60);
  assign bound   = $signed(drlt_pkg::SEC_W'(prod_r)) + drlt_pkg::SEC_W'(shift_r);
  assign t_sec   = $signed(drlt_pkg::SEC_W'(utc_r));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      drlt_pkg::S_IDLE: begin
        if (start_i) begin
          state_nxt = (cfg_i.dst_mode == drlt_pkg::MODE_RULE) ? drlt_pkg::S_DIV
                                                                : drlt_pkg::S_DONE;
        end
      end
      drlt_pkg::S_DIV: begin
        if (div_done) begin
          state_nxt = drlt_pkg::S_YEAR;
        end
      end
      drlt_pkg::S_YEAR: begin
        if (rdays_r < ylen) begin
          state_nxt = drlt_pkg::S_RULE;
        end
      end
      drlt_pkg::S_RULE:  state_nxt = rule_ok ? drlt_pkg::S_MONTH : drlt_pkg::S_DONE;
      drlt_pkg::S_MONTH: begin
        if (mon_r >= rule_mon) begin
          state_nxt = drlt_pkg::S_DATE;
        end
      end
      drlt_pkg::S_DATE:  state_nxt = date_ok ? drlt_pkg::S_MUL : drlt_pkg::S_DONE;
      drlt_pkg::S_MUL:   state_nxt = drlt_pkg::S_SUM;
      drlt_pkg::S_SUM:   state_nxt = sel_r ? drlt_pkg::S_CMP : drlt_pkg::S_RULE;
      drlt_pkg::S_CMP:   state_nxt = drlt_pkg::S_DONE;
      drlt_pkg::S_DONE: begin
        if (ack_i) begin
          state_nxt = drlt_pkg::S_IDLE;
        end
      end
      default: state_nxt = drlt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    utc_nxt    = utc_r;
    rdays_nxt  = rdays_r;
    ystart_nxt = ystart_r;
    yoff_nxt   = yoff_r;
    ywd_nxt    = ywd_r;
    sel_nxt    = sel_r;
    mon_nxt    = mon_r;
    first_nxt  = first_r;
    fdw_nxt    = fdw_r;
    day_nxt    = day_r;
    prod_nxt   = prod_r;
    shift_nxt  = shift_r;
    s_nxt      = s_r;
    e_nxt      = e_r;
    active_nxt = active_r;
    unique case (state_r)
      drlt_pkg::S_IDLE: begin
        if (start_i) begin
          utc_nxt    = utc_i;
          shift_nxt  = hr_sec - off_sec;
          active_nxt = (cfg_i.dst_mode == drlt_pkg::MODE_ON);
        end
      end
      drlt_pkg::S_DIV: begin
        rdays_nxt  = div_quot;
        ystart_nxt = '0;
        yoff_nxt   = '0;
        ywd_nxt    = drlt_pkg::EPOCH_WEEKDAY;
        sel_nxt    = 1'b0;
      end
      drlt_pkg::S_YEAR: begin
        if (rdays_r >= ylen) begin
          rdays_nxt  = rdays_r - ylen;
          ystart_nxt = ystart_r + ylen;
          yoff_nxt   = yoff_r + 1'b1;
          ywd_nxt    = drlt_pkg::add_mod7(ywd_r, leap ? 3'd2 : 3'd1);
        end else begin
          mon_nxt   = 4'd1;
          first_nxt = ystart_r;
          fdw_nxt   = ywd_r;
        end
      end
      drlt_pkg::S_RULE: begin
        active_nxt = 1'b0;
      end
      drlt_pkg::S_MONTH: begin
        if (mon_r < rule_mon) begin
          first_nxt = first_r + drlt_pkg::DAY_W'(mlen);
          fdw_nxt   = drlt_pkg::add_mod7(fdw_r, 3'(mlen - 5'd28));
          mon_nxt   = mon_r + 1'b1;
        end
      end
      drlt_pkg::S_DATE: begin
        day_nxt = first_r + drlt_pkg::DAY_W'(date) - 1'b1;
      end
      drlt_pkg::S_MUL: begin
        prod_nxt = drlt_pkg::PROD_W'(day_r) * drlt_pkg::PROD_W'(drlt_pkg::SECS_PER_DAY);
      end
      drlt_pkg::S_SUM: begin
        if (sel_r) begin
          e_nxt = bound;
        end else begin
          s_nxt     = bound;
          sel_nxt   = 1'b1;
          mon_nxt   = 4'd1;
          first_nxt = ystart_r;
          fdw_nxt   = ywd_r;
        end
      end
      drlt_pkg::S_CMP: begin
        if (s_r < e_r) begin
          active_nxt = (t_sec >= s_r) && (t_sec < e_r);
        end else if (s_r > e_r) begin
          active_nxt = (t_sec >= s_r) || (t_sec < e_r);
        end else begin
          active_nxt = 1'b0;
        end
      end
      drlt_pkg::S_DONE: begin
        active_nxt = active_r;
      end
      default: active_nxt = active_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= drlt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    utc_r    <= utc_nxt;
    rdays_r  <= rdays_nxt;
    ystart_r <= ystart_nxt;
    yoff_r   <= yoff_nxt;
    ywd_r    <= ywd_nxt;
    sel_r    <= sel_nxt;
    mon_r    <= mon_nxt;
    first_r  <= first_nxt;
    fdw_r    <= fdw_nxt;
    day_r    <= day_nxt;
    prod_r   <= prod_nxt;
    shift_r  <= shift_nxt;
    s_r      <= s_nxt;
    e_r      <= e_nxt;
    active_r <= active_nxt;
  end

  assign idle_o   = (state_r == drlt_pkg::S_IDLE);
  assign done_o   = (state_r == drlt_pkg::S_DONE);
  assign active_o = active_r;
  assign utc_o    = utc_r;

`ifndef SYNTH
  a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == drlt_pkg::S_YEAR) |-> (yoff_r <= drlt_pkg::YOFF_LAST))
    else $error("year walk ran past the 32-bit epoch range");
  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == drlt_pkg::S_DATE) |-> (mon_r == rule_mon))
    else $error("month walk stopped at the wrong month");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == drlt_pkg::S_DIV))
    else $error("day count finished outside the division step");
`endif

endmodule

// ===== design/dst_rule_local_time.sv =====
// Top level: configuration registers, word handshake and local-time result register.
// Converts a UTC second count into the daylight-saving flag, the total offset in minutes
// and local seconds. A word is accepted only while the sequencer is idle; in_ready is low
// until its result has been moved into the output register, which may still hold an earlier
// result waiting for out_ready. With dst_mode other than the fixed rule the sequencer goes
// straight from idle to its done state. With the fixed rule it runs a registered reciprocal
// multiplication for the day count, a year walk that advances one year per cycle, then for
// each rule a validity check, a month walk up to the rule's month, a date step, a multiply
// step and a sum step for the switch instant, then a final compare. An invalid rule or date
// ends the walk early. While a waiting result is held off by out_ready, the sequencer stays
// in its done state. Configuration is written through cfg_wr_en, cfg_index and cfg_wdata;
// the user must write it only while no word is in flight, as the block does not enforce it.
module dst_rule_local_time (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [drlt_pkg::IDX_W-1:0]            cfg_index,
  input  logic [drlt_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [31:0]                           in_utc_seconds,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_dst_active,
  output logic signed [10:0]                    out_offset_minutes,
  output logic signed [33:0]                    out_local_seconds
);

  drlt_pkg::cfg_t      cfg_r;
  logic                out_valid_r;
  logic                out_dst_active_r;
  logic signed [10:0]  out_offset_minutes_r;
  logic signed [33:0]  out_local_seconds_r;

  logic                seq_idle;
  logic                seq_done;
  logic                seq_active;
  logic [31:0]         seq_utc;
  logic                ack;
  logic                accept;
  logic signed [11:0]  off_sum;
  logic signed [10:0]  off_sat;
  logic signed [16:0]  off_sec;
  logic signed [33:0]  loc_sum;

  assign ack    = !out_valid_r || out_ready;
  assign accept = in_valid && in_ready;

  drlt_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_i    (cfg_r),
    .start_i  (accept),
    .utc_i    (in_utc_seconds),
    .ack_i    (ack),
    .idle_o   (seq_idle),
    .done_o   (seq_done),
    .active_o (seq_active),
    .utc_o    (seq_utc)
  );

  assign in_ready = seq_idle;

  always_comb begin
    off_sum = 12'(cfg_r.base_off) +
              $signed({5'b0, (seq_active ? cfg_r.dst_extra_min : 7'd0)});
    if (off_sum > drlt_pkg::OFF_MAX) begin
      off_sat = 11'(drlt_pkg::OFF_MAX);
    end else if (off_sum < drlt_pkg::OFF_MIN) begin
      off_sat = 11'(drlt_pkg::OFF_MIN);
    end else begin
      off_sat = off_sum[10:0];
    end
    off_sec = 17'(off_sat) * $signed(17'd60);
    loc_sum = $signed(34'(seq_utc)) + 34'(off_sec);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_off      <= 11'sd480;
      cfg_r.dst_extra_min <= 7'd60;
      cfg_r.dst_mode      <= drlt_pkg::MODE_OFF;
      cfg_r.start_rule    <= '0;
      cfg_r.end_rule      <= '0;
      cfg_r.sw_hr         <= 5'd2;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        drlt_pkg::REG_STD_OFFSET: cfg_r.base_off      <= $signed(cfg_wdata[10:0]);
        drlt_pkg::REG_DST_EXTRA:  cfg_r.dst_extra_min <= cfg_wdata[6:0];
        drlt_pkg::REG_DST_MODE:   cfg_r.dst_mode      <= cfg_wdata[1:0];
        drlt_pkg::REG_START_RULE: cfg_r.start_rule    <= cfg_wdata[9:0];
        drlt_pkg::REG_END_RULE:   cfg_r.end_rule      <= cfg_wdata[9:0];
        drlt_pkg::REG_SWITCH_HR:  cfg_r.sw_hr         <= cfg_wdata[4:0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_done && ack) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_done && ack) begin
      out_dst_active_r     <= seq_active;
      out_offset_minutes_r <= off_sat;
      out_local_seconds_r  <= loc_sum;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_dst_active     = out_dst_active_r;
  assign out_offset_minutes = out_offset_minutes_r;
  assign out_local_seconds  = out_local_seconds_r;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready) else $error("input still ready after a word was taken");
`endif

endmodule
